// File: rtl/core/wmf_pkg.sv
// Shared constants, register indexes and controller/datapath interface types.
package wmf_pkg;

  // Largest supported image width and window radius.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_RADIUS = 7;
  localparam int MAX_HEIGHT = 1024;

  // Pixel and register widths.
  localparam int PIX_W = 8;
  localparam int DIM_W = 11;
  localparam int RAD_W = 3;
  localparam int CFG_W = 11;
  localparam int IDX_W = 2;

  // Line store holds the most recent 2*R rows plus 2*R+1 pixels.
  localparam int STORE_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Position counters and window counters.
  localparam int POS_W  = 21;
  localparam int RC_W   = 10;
  localparam int SIDE_W = 4;
  localparam int CNT_W  = 8;
  localparam int PASS_W = 3;
  localparam int LAG_W  = 14;
  localparam int SRC_W  = 12;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_WINDOW_RADIUS = 2'd2;

  // Input command codes.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic pass_init;
    logic scan;
    logic update;
    logic finish;
  } wmf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic produce;
    logic scan_last;
    logic pass_last;
    logic out_free;
  } wmf_status_t;

endpackage

// File: rtl/core/wmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/wmf_ctrl.sv
// Controller state machine that sequences the median search passes.
module wmf_ctrl import wmf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  wmf_status_t status,
  output wmf_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (status.produce) begin
            state_next = ST_START;
          end
        end
      end
      ST_START: begin
        cmd.pass_init = 1'b1;
        state_next    = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = status.pass_last ? ST_DONE : ST_START;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/core/wmf_dp.sv
// Datapath: registers, line store addressing, window scan and rank search.
module wmf_dp import wmf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_cmd,
  input  logic [PIX_W-1:0]  in_pixel,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [PIX_W-1:0]  m_data,
  output logic              m_last,
  input  wmf_cmd_t          cmd,
  output wmf_status_t       status
);

  // Configuration, stored already clamped.
  logic [DIM_W-1:0] img_w;
  logic [DIM_W-1:0] img_h;
  logic [RAD_W-1:0] rad;
  logic [DIM_W-1:0] cfg_dim;
  logic [RAD_W-1:0] cfg_rad;
  logic             cfg_hit;

  // Position state.
  logic [POS_W-1:0]  in_pos;
  logic [POS_W-1:0]  out_pos;
  logic [ADDR_W-1:0] wptr;
  logic [ADDR_W-1:0] cur_wr;
  logic [RC_W-1:0]   out_row;
  logic [RC_W-1:0]   out_col;

  // Search state.
  logic [PIX_W-1:0]  lo;
  logic [PIX_W-1:0]  hi;
  logic [PIX_W-1:0]  mid;
  logic [PASS_W-1:0] pass;
  logic [CNT_W-1:0]  cnt;
  logic              pend;
  logic              pend_in;
  logic [SIDE_W-1:0] dr;
  logic [SIDE_W-1:0] dc;
  logic [ADDR_W-1:0] addr;

  // Derived values.
  logic [LAG_W-1:0]  lag;
  logic [POS_W-1:0]  total;
  logic [SIDE_W-1:0] side_m1;
  logic [CNT_W-1:0]  rank;
  logic [ADDR_W-1:0] row_step;
  logic [ADDR_W:0]   start_sum;
  logic [ADDR_W-1:0] start_addr;
  logic [ADDR_W:0]   row_sum;
  logic [ADDR_W-1:0] row_addr;
  logic [ADDR_W-1:0] col_addr;
  logic signed [SRC_W-1:0] rr;
  logic signed [SRC_W-1:0] cc;
  logic              in_img;
  logic              out_end;
  logic [PIX_W-1:0]  wr_val;
  logic [PIX_W-1:0]  rd_val;
  logic [POS_W-1:0]  out_pos_inc;

  // Clamp of written dimension and radius values.
  always_comb begin
    if (cfg_data == '0) begin
      cfg_dim = DIM_W'(1);
    end else if (cfg_data > CFG_W'(MAX_WIDTH)) begin
      cfg_dim = DIM_W'(MAX_WIDTH);
    end else begin
      cfg_dim = cfg_data;
    end
    if (cfg_data[RAD_W-1:0] == '0) begin
      cfg_rad = RAD_W'(1);
    end else if (cfg_data[RAD_W-1:0] > RAD_W'(MAX_RADIUS)) begin
      cfg_rad = RAD_W'(MAX_RADIUS);
    end else begin
      cfg_rad = cfg_data[RAD_W-1:0];
    end
    cfg_hit = cfg_we && (cfg_addr == CFG_IMAGE_WIDTH || cfg_addr == CFG_IMAGE_HEIGHT ||
                         cfg_addr == CFG_WINDOW_RADIUS);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= DIM_W'(512);
      img_h <= DIM_W'(512);
      rad   <= RAD_W'(3);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_IMAGE_WIDTH:   img_w <= cfg_dim;
        CFG_IMAGE_HEIGHT:  img_h <= (cfg_dim > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : cfg_dim;
        CFG_WINDOW_RADIUS: rad   <= cfg_rad;
        default: ;
      endcase
    end
  end

  // Window geometry derived from the configuration.
  always_comb begin
    side_m1  = {rad, 1'b0};
    lag      = LAG_W'(rad) * LAG_W'(img_w) + LAG_W'(rad);
    total    = POS_W'(img_w) * POS_W'(img_h);
    rank     = CNT_W'(({4'd0, side_m1} + 8'd1) * ({4'd0, side_m1} + 8'd1) / 2);
    if (img_w >= DIM_W'(side_m1)) begin
      row_step = ADDR_W'(img_w - DIM_W'(side_m1));
    end else begin
      row_step = ADDR_W'(STORE_DEPTH) + ADDR_W'(img_w) - ADDR_W'(side_m1);
    end
    start_sum = {1'b0, cur_wr} + (ADDR_W + 1)'(STORE_DEPTH) - (ADDR_W + 1)'({lag, 1'b0});
    start_addr = (start_sum >= (ADDR_W + 1)'(STORE_DEPTH)) ?
                 ADDR_W'(start_sum - (ADDR_W + 1)'(STORE_DEPTH)) : start_sum[ADDR_W-1:0];
    row_sum  = {1'b0, addr} + {1'b0, row_step};
    row_addr = (row_sum >= (ADDR_W + 1)'(STORE_DEPTH)) ?
               ADDR_W'(row_sum - (ADDR_W + 1)'(STORE_DEPTH)) : row_sum[ADDR_W-1:0];
    col_addr = (addr == ADDR_W'(STORE_DEPTH - 1)) ? '0 : addr + ADDR_W'(1);
    mid      = lo + ((hi - lo) >> 1);
  end

  // Whether the window position being read lies inside the image.
  always_comb begin
    rr = $signed({2'b00, out_row}) - $signed(SRC_W'(rad)) + $signed(SRC_W'(dr));
    cc = $signed({2'b00, out_col}) - $signed(SRC_W'(rad)) + $signed(SRC_W'(dc));
    in_img = !rr[SRC_W-1] && (rr < $signed({1'b0, img_h})) &&
             !cc[SRC_W-1] && (cc < $signed({1'b0, img_w}));
  end

  // Status and store write data.
  always_comb begin
    status.produce   = (in_pos >= POS_W'(lag)) && (out_pos < total);
    status.scan_last = (dr == side_m1) && (dc == side_m1);
    status.pass_last = (pass == PASS_W'(PIX_W - 1));
    status.out_free  = !m_tvalid || m_tready;
    wr_val      = (in_cmd == CMD_PIXEL && in_pos < total) ? in_pixel : '0;
    out_pos_inc = out_pos + POS_W'(1);
    out_end     = (out_pos_inc >= total);
  end

  // Line store.
  wmf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (wptr),
    .wdata (wr_val),
    .raddr (addr),
    .rdata (rd_val)
  );

  // Input and output positions.
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      in_pos  <= '0;
      out_pos <= '0;
      wptr    <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (cmd.accept) begin
      in_pos <= in_pos + POS_W'(1);
      wptr   <= (wptr == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wptr + ADDR_W'(1);
    end else if (cmd.finish) begin
      if (out_end) begin
        in_pos  <= '0;
        out_pos <= '0;
        wptr    <= '0;
        out_row <= '0;
        out_col <= '0;
      end else begin
        out_pos <= out_pos_inc;
        if ({1'b0, out_col} + DIM_W'(1) == img_w) begin
          out_col <= '0;
          out_row <= out_row + RC_W'(1);
        end else begin
          out_col <= out_col + RC_W'(1);
        end
      end
    end
  end

  // Window scan and rank search.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_wr <= wptr;
      lo     <= '0;
      hi     <= '1;
      pass   <= '0;
    end
    if (cmd.pass_init) begin
      dr   <= '0;
      dc   <= '0;
      addr <= start_addr;
      cnt  <= '0;
    end else begin
      if (cmd.scan) begin
        if (dc == side_m1) begin
          dc   <= '0;
          dr   <= dr + SIDE_W'(1);
          addr <= row_addr;
        end else begin
          dc   <= dc + SIDE_W'(1);
          addr <= col_addr;
        end
      end
      // Count window values not above the midpoint, one a cycle.
      if (pend) begin
        cnt <= cnt + CNT_W'(pend_in ? (rd_val <= mid) : 1'b1);
      end
    end
    if (cmd.update) begin
      pass <= pass + PASS_W'(1);
      if (cnt > rank) begin
        hi <= mid;
      end else begin
        lo <= mid + PIX_W'(1);
      end
    end
    pend_in <= in_img;
  end

  // Read pending flag.
  always_ff @(posedge clk) begin
    if (rst || cmd.pass_init) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.scan;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_data <= lo;
      m_last <= out_end;
    end
  end

endmodule

// File: rtl/core/window_median_filter.sv
// Top level: zero-padded square-window median filter for raster pixel streams.
// An item that yields a result is resolved by eight passes over the window through
// the single read port of the line store; no new input word is taken until then.
// A result waits in the output register while the next word is taken.
// Reset is synchronous and active high; it restores the default configuration.
module window_median_filter import wmf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [PIX_W-1:0]  s_tdata,   // [7:0] pixel_value
  input  logic              s_tuser,   // [0] command
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [PIX_W-1:0]  m_tdata,   // [7:0] median_value
  output logic              m_tlast,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]  cfg_data
);

  wmf_cmd_t    cmd;
  wmf_status_t status;

  // Sequencer.
  wmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath with line store.
  wmf_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .in_cmd   (s_tuser),
    .in_pixel (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_data   (m_tdata),
    .m_last   (m_tlast),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

// File: rtl/core/wmf_checker.sv
// Port checker for the median filter, bound to the top level.
module wmf_port_checker import wmf_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [PIX_W-1:0] m_tdata,
  input logic             m_tlast
);

  // Reset leaves no result pending.
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word present after reset");

  // Reset leaves the block ready for input.
  a_rst_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result word changed");

  // A new result word needs an accepted input word before it.
  a_cause: assert property (@(posedge clk) disable iff (rst)
    s_tready && !s_tvalid && !m_tvalid |=> !m_tvalid)
    else $error("result word without input word");

endmodule

bind window_median_filter wmf_port_checker u_wmf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// File: tb/wmf_checker.sv
// Checker for the median filter: predicts each filtered pixel and compares results.
`timescale 1ns / 100ps
module wmf_checker import wmf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [PIX_W-1:0]  s_tdata,
  input  logic              s_tuser,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [PIX_W-1:0]  m_tdata,
  input  logic              m_tlast,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]  cfg_data,
  output int                fail_count,
  output int                medians_pending
);

  typedef struct {
    logic [PIX_W-1:0] median;
    logic             last;
  } median_word_t;

  // Shadow of the configuration and of the image seen so far.
  logic [DIM_W-1:0] width_reg, height_reg;
  logic [RAD_W-1:0] radius_reg;
  logic [PIX_W-1:0] image_pix [0:MAX_WIDTH*MAX_HEIGHT-1];
  int in_pos, out_pos;
  median_word_t median_queue [$];

  // Median of the zero-padded window around raster index k, by histogram rank.
  function automatic logic [PIX_W-1:0] window_median(int k, int w, int h, int rad);
    int hist [256];
    int r, c, rr, cc, side, rank, cum;
    for (int v = 0; v < 256; v++) hist[v] = 0;
    r = k / w;
    c = k % w;
    side = 2 * rad + 1;
    for (int dr = -rad; dr <= rad; dr++) begin
      for (int dc = -rad; dc <= rad; dc++) begin
        rr = r + dr;
        cc = c + dc;
        if (rr >= 0 && rr < h && cc >= 0 && cc < w) hist[image_pix[rr * w + cc]]++;
        else hist[0]++;
      end
    end
    rank = (side * side) / 2;
    cum = 0;
    for (int v = 0; v < 256; v++) begin
      cum += hist[v];
      if (cum > rank) return v[PIX_W-1:0];
    end
    return '1;
  endfunction

  always @(posedge clk) begin
    int w, h, rad, total, lag;
    median_word_t got, exp_word;
    logic [PIX_W-1:0] pix;
    if (rst) begin
      width_reg  = 11'd512;
      height_reg = 11'd512;
      radius_reg = 3'd3;
      in_pos = 0;
      out_pos = 0;
      fail_count = 0;
      median_queue.delete();
    end else begin
      // Result side first: a word cannot answer an input taken at the same edge.
      if (m_tvalid && m_tready) begin
        got.median = m_tdata;
        got.last   = m_tlast;
        if (median_queue.size() == 0) begin
          $display("%0t: unexpected result word: median %0d last %0d", $time,
                   got.median, got.last);
          fail_count++;
        end else begin
          exp_word = median_queue.pop_front();
          if (got.median !== exp_word.median) begin
            $display("%0t: median mismatch: expected %0d actual %0d", $time,
                     exp_word.median, got.median);
            fail_count++;
          end
          if (got.last !== exp_word.last) begin
            $display("%0t: last flag mismatch: expected %0d actual %0d", $time,
                     exp_word.last, got.last);
            fail_count++;
          end
        end
      end
      // Register writes abandon any image in progress.
      if (cfg_we) begin
        case (cfg_addr)
          CFG_IMAGE_WIDTH: begin
            width_reg = cfg_data;
          end
          CFG_IMAGE_HEIGHT: begin
            height_reg = cfg_data;
          end
          CFG_WINDOW_RADIUS: begin
            radius_reg = cfg_data[RAD_W-1:0];
          end
          default: ;
        endcase
        if (cfg_addr == CFG_IMAGE_WIDTH || cfg_addr == CFG_IMAGE_HEIGHT ||
            cfg_addr == CFG_WINDOW_RADIUS) begin
          in_pos = 0;
          out_pos = 0;
        end
      end
      // Input side: store the pixel, then predict the result it releases.
      if (s_tvalid && s_tready) begin
        w   = (width_reg < 1) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h   = (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        rad = (radius_reg < 1) ? 1 : (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
        total = w * h;
        lag = rad * w + rad;
        pix = (s_tuser == CMD_PIXEL) ? s_tdata : '0;
        if (in_pos < total) image_pix[in_pos] = pix;
        if (in_pos >= lag && out_pos < total) begin
          exp_word.median = window_median(out_pos, w, h, rad);
          exp_word.last   = (out_pos + 1 == total);
          median_queue.push_back(exp_word);
          out_pos++;
          in_pos++;
          if (out_pos >= total) begin
            in_pos = 0;
            out_pos = 0;
          end
        end else begin
          in_pos++;
        end
      end
    end
    medians_pending = median_queue.size();
  end

endmodule

// File: tb/testbench.sv
// Top of the median filter testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module testbench;
  import wmf_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 1900;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [PIX_W-1:0] s_tdata = '0;   // [7:0] pixel_value
  logic             s_tuser = 1'b0; // [0] command
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [PIX_W-1:0] m_tdata;        // [7:0] median_value
  logic             m_tlast;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  int fail_count, medians_pending;
  int send_idle, recv_idle, words_sent, stall_cycles;

  window_median_filter u_top (.*);

  wmf_checker u_checker (.*);

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    m_tready = ($urandom_range(0, 99) >= recv_idle);
  end

  // Watchdog: too long without any word moving ends the run.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Idling profile follows progress through the run.
  task automatic set_idling();
    if (words_sent < 300) begin
      send_idle = 14;
      recv_idle = 45;
    end else if (words_sent < 600) begin
      send_idle = 45;
      recv_idle = 14;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  endtask

  // Send one input word and wait for it to be taken.
  task automatic send_word(logic cmd, logic [PIX_W-1:0] pix);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = pix;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // Drain all results, let the block settle, then write the three registers.
  task automatic configure(int w, int h, int rad);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (medians_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = CFG_IMAGE_WIDTH;
    cfg_data = w[CFG_W-1:0];
    @(negedge clk);
    cfg_addr = CFG_IMAGE_HEIGHT;
    cfg_data = h[CFG_W-1:0];
    @(negedge clk);
    cfg_addr = CFG_WINDOW_RADIUS;
    cfg_data = rad[CFG_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One image plus its flush tail; count_limit below the full length abandons it.
  task automatic run_image(int w, int h, int rad, int count_limit);
    int total, lag;
    logic [PIX_W-1:0] pix;
    total = w * h;
    lag = rad * w + rad;
    for (int i = 0; i < total + lag && i < count_limit; i++) begin
      pix = $urandom_range(0, 255);
      if ($urandom_range(0, 3) == 0) pix = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      if (i < total) send_word(($urandom_range(0, 19) == 0) ? CMD_FLUSH : CMD_PIXEL, pix);
      else send_word(($urandom_range(0, 2) == 0) ? CMD_PIXEL : CMD_FLUSH, pix);
    end
  endtask

  initial begin
    int w, h, rad, total, lag;
    words_sent = 0;
    stall_cycles = 0;
    send_idle = 14;
    recv_idle = 45;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: small image with extremes, a flush inside, pixels past the end.
    configure(4, 3, 1);
    send_word(CMD_PIXEL, 8'h00);
    send_word(CMD_PIXEL, 8'hFF);
    send_word(CMD_PIXEL, 8'hFF);
    send_word(CMD_PIXEL, 8'hAA);
    send_word(CMD_FLUSH, 8'hFF);
    send_word(CMD_PIXEL, 8'h55);
    send_word(CMD_PIXEL, 8'hFF);
    send_word(CMD_PIXEL, 8'h01);
    send_word(CMD_PIXEL, 8'h80);
    send_word(CMD_PIXEL, 8'hFF);
    send_word(CMD_PIXEL, 8'h7F);
    send_word(CMD_PIXEL, 8'hFE);
    send_word(CMD_PIXEL, 8'hFF);
    send_word(CMD_FLUSH, 8'h00);
    send_word(CMD_PIXEL, 8'h33);
    send_word(CMD_FLUSH, 8'hFF);
    send_word(CMD_PIXEL, 8'hFF);
    // Out-of-range registers clamp: zero width, height and radius.
    configure(0, 0, 0);
    run_image(1, 1, 1, 1 << 30);
    // Largest radius on a small image, then oversized width and height, sent in part.
    configure(9, 5, 7);
    run_image(9, 5, 7, 1 << 30);
    configure(2047, 1, 1);
    run_image(1024, 1, 1, 40);
    configure(1, 2047, 1);
    run_image(1, 1024, 1, 60);

    // Random images, some abandoned part way by a register write.
    while (words_sent < 850) begin
      set_idling();
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 6);
      rad = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : $urandom_range(1, 3);
      total = w * h;
      lag = rad * w + rad;
      configure(w, h, rad);
      if ($urandom_range(0, 9) == 0) run_image(w, h, rad, $urandom_range(0, total + lag - 1));
      else run_image(w, h, rad, 1 << 30);
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    while (medians_pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
